### rtl/sorted_priority_queue_top_macros.svh
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication, checked on the rising edge of clock outside reset
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on the rising edge of clock outside reset
`define SPQ_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/spq_pkg.sv
// types and constants shared by the sorted priority queue modules
package spq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;
   localparam int PRIO_W   = 16;

   localparam logic [FUNC_W-1:0] FUNC_ENQ  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEQ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
   } item_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

### rtl/spq_cell.sv
// one slot of the shift-register priority queue
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  spq_pkg::item_type     new_item,
   input  spq_pkg::item_type     left_item,
   input  logic                  left_stays,
   input  spq_pkg::item_type     right_item,
   output spq_pkg::item_type     slot_item,
   output logic                  stays
);

   spq_pkg::item_type slot_ff;
   spq_pkg::item_type slot_in;

   // an occupied slot keeps its place when its priority is not below the new one
   assign stays     = occupied && !(slot_ff.prio < new_item.prio);
   assign slot_item = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.remove) begin
         slot_in = right_item;
      end else if (ctrl.insert) begin
         if (stays) begin
            slot_in = slot_ff;
         end else if (left_stays) begin
            slot_in = new_item;
         end else begin
            slot_in = left_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

### rtl/sorted_priority_queue_top.sv
// sorted priority queue: a row of slot cells kept in descending priority order
//
// requests enter on req_valid/req_ready with req_func (0 enqueue, 1 dequeue,
// 2 peek), req_item_data and req_item_priority; the last two matter only for
// enqueue. every request gives exactly one response on rsp_valid/rsp_ready
// with rsp_status (0 ok, 1 empty, 2 full), the head entry for a dequeue or
// peek that found one (zero otherwise) and the entry count after the request.
// each cell compares its priority with the incoming one in parallel, so an
// insert or removal finishes in the cycle it is accepted: one request per
// cycle while req_ready is high, response valid the cycle after acceptance.
// equal priorities leave in arrival order since new entries go behind them.
// the response sits in an output register; req_ready is high while that
// register is empty or being drained, so a stalled receiver holds at most one
// response and then backpressures the request side.
// reset empties the queue at once (count to zero) and drops any pending
// response; slot contents are not cleared since slots past the count are
// never read.
module sorted_priority_queue_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [spq_pkg::FUNC_W-1:0]            req_func,
   input  logic signed [spq_pkg::DATA_W-1:0]     req_item_data,
   input  logic signed [spq_pkg::PRIO_W-1:0]     req_item_priority,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [spq_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [spq_pkg::DATA_W-1:0]     rsp_head_data,
   output logic signed [spq_pkg::PRIO_W-1:0]     rsp_head_priority,
   output logic [spq_pkg::CNT_W-1:0]             rsp_entry_count
);

`include "sorted_priority_queue_top_macros.svh"

   logic                           accept;
   logic                           full;
   logic                           empty;
   logic                           do_insert;
   logic                           do_remove;
   spq_pkg::cell_ctrl_type         cell_ctrl;
   spq_pkg::item_type              new_item;
   spq_pkg::item_type              cell_item [spq_pkg::DEPTH];
   logic                           cell_stays [spq_pkg::DEPTH];

   logic [spq_pkg::CNT_W-1:0]      count_ff;
   logic [spq_pkg::CNT_W-1:0]      count_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [spq_pkg::STATUS_W-1:0]   status_ff;
   logic [spq_pkg::STATUS_W-1:0]   status_in;
   spq_pkg::item_type              head_ff;
   spq_pkg::item_type              head_in;
   logic [spq_pkg::CNT_W-1:0]      rsp_count_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == spq_pkg::CNT_W'(spq_pkg::DEPTH));
   assign empty     = (count_ff == '0);
   assign do_insert = accept && (req_func == spq_pkg::FUNC_ENQ) && !full;
   assign do_remove = accept && (req_func == spq_pkg::FUNC_DEQ) && !empty;

   assign cell_ctrl.insert = do_insert;
   assign cell_ctrl.remove = do_remove;
   assign new_item.data    = req_item_data;
   assign new_item.prio    = req_item_priority;

   genvar gi;
   generate
      for (gi = 0; gi < spq_pkg::DEPTH; gi++) begin : g_cell
         spq_pkg::item_type left_item;
         spq_pkg::item_type right_item;
         logic              left_stays;

         if (gi == 0) begin : g_first
            assign left_item  = '0;
            assign left_stays = 1'b1;
         end else begin : g_inner_l
            assign left_item  = cell_item[gi-1];
            assign left_stays = cell_stays[gi-1];
         end

         if (gi == spq_pkg::DEPTH - 1) begin : g_last
            assign right_item = '0;
         end else begin : g_inner_r
            assign right_item = cell_item[gi+1];
         end

         spq_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl),
            .occupied   (spq_pkg::CNT_W'(gi) < count_ff),
            .new_item   (new_item),
            .left_item  (left_item),
            .left_stays (left_stays),
            .right_item (right_item),
            .slot_item  (cell_item[gi]),
            .stays      (cell_stays[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + spq_pkg::CNT_W'(1);
      end else if (do_remove) begin
         count_in = count_ff - spq_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      status_in = spq_pkg::STAT_OK;
      head_in   = '0;
      case (req_func)
         spq_pkg::FUNC_ENQ: begin
            if (full) begin
               status_in = spq_pkg::STAT_FULL;
            end
         end
         spq_pkg::FUNC_DEQ, spq_pkg::FUNC_PEEK: begin
            if (empty) begin
               status_in = spq_pkg::STAT_EMPTY;
            end else begin
               head_in = cell_item[0];
            end
         end
         default: begin
            status_in = spq_pkg::STAT_OK;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload loads only on an accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         head_ff      <= head_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_head_data     = head_ff.data;
   assign rsp_head_priority = head_ff.prio;
   assign rsp_entry_count   = rsp_count_ff;

   `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= spq_pkg::CNT_W'(spq_pkg::DEPTH), "count above depth")
   `SPQ_ASSERT_NXT(a_accept_rsp, accept, rsp_valid_ff, "accepted request gave no response")
   `SPQ_ASSERT_NXT(a_remove_dec, do_remove, count_ff == $past(count_ff) - spq_pkg::CNT_W'(1), "dequeue did not drop count")
   `SPQ_ASSERT_IMP(a_full_count, rsp_valid_ff && (rsp_status == spq_pkg::STAT_FULL), rsp_entry_count == spq_pkg::CNT_W'(spq_pkg::DEPTH), "full status below depth")
   `SPQ_ASSERT_IMP(a_empty_count, rsp_valid_ff && (rsp_status == spq_pkg::STAT_EMPTY), rsp_entry_count == '0, "empty status with entries")

endmodule

### tb/sv/sorted_priority_queue_top_tb.sv
// testbench for the sorted priority queue: directed and random requests against a scoreboard
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;

   localparam logic [spq_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int MAX_PRINTS    = 40;
   localparam int TAIL_CYCLES   = 10;
   localparam longint RUN_LIMIT_NS = 5_000_000;

   typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} segment_type;
   typedef enum int {PRIO_FULL, PRIO_TIES, PRIO_EXTREME} prio_mode_type;
   typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PERIODIC} rx_mode_type;

   typedef struct {
      logic [spq_pkg::STATUS_W-1:0]      status;
      logic signed [spq_pkg::DATA_W-1:0] data;
      logic signed [spq_pkg::PRIO_W-1:0] prio;
      logic [spq_pkg::CNT_W-1:0]         count;
   } response_type;

   // shadow copy of the sorted store and the responses still to come
   class queue_scoreboard;
      logic signed [spq_pkg::DATA_W-1:0] slot_data[spq_pkg::DEPTH];
      logic signed [spq_pkg::PRIO_W-1:0] slot_prio[spq_pkg::DEPTH];
      int           fill;
      response_type expected_rsp[$];
      int errors;
      int n_checked, n_enq, n_full, n_deq, n_peek, n_empty, n_unused, max_fill;

      function new();
         fill = 0;
         errors = 0;
         n_checked = 0; n_enq = 0; n_full = 0; n_deq = 0;
         n_peek = 0; n_empty = 0; n_unused = 0; max_fill = 0;
      endfunction

      function int outstanding();
         return expected_rsp.size();
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, msg);
      endtask

      function void note_request(logic [spq_pkg::FUNC_W-1:0] func,
                                 logic signed [spq_pkg::DATA_W-1:0] d,
                                 logic signed [spq_pkg::PRIO_W-1:0] p);
         response_type r;
         int pos;
         r.status = spq_pkg::STAT_OK;
         r.data   = '0;
         r.prio   = '0;
         if (func == spq_pkg::FUNC_ENQ) begin
            if (fill >= spq_pkg::DEPTH) begin
               r.status = spq_pkg::STAT_FULL;
               n_full++;
            end else begin
               // new entry goes behind every entry of equal priority
               pos = fill;
               while (pos > 0 && slot_prio[pos-1] < p) begin
                  slot_data[pos] = slot_data[pos-1];
                  slot_prio[pos] = slot_prio[pos-1];
                  pos--;
               end
               slot_data[pos] = d;
               slot_prio[pos] = p;
               fill++;
               n_enq++;
               if (fill > max_fill) max_fill = fill;
            end
         end else if (func == spq_pkg::FUNC_DEQ || func == spq_pkg::FUNC_PEEK) begin
            if (fill == 0) begin
               r.status = spq_pkg::STAT_EMPTY;
               n_empty++;
            end else begin
               r.data = slot_data[0];
               r.prio = slot_prio[0];
               if (func == spq_pkg::FUNC_DEQ) begin
                  for (int k = 1; k < fill; k++) begin
                     slot_data[k-1] = slot_data[k];
                     slot_prio[k-1] = slot_prio[k];
                  end
                  fill--;
                  n_deq++;
               end else begin
                  n_peek++;
               end
            end
         end else begin
            n_unused++;
         end
         r.count = fill[spq_pkg::CNT_W-1:0];
         expected_rsp.push_back(r);
      endfunction

      task check_response(logic [spq_pkg::STATUS_W-1:0] st,
                          logic signed [spq_pkg::DATA_W-1:0] d,
                          logic signed [spq_pkg::PRIO_W-1:0] p,
                          logic [spq_pkg::CNT_W-1:0] c);
         response_type e;
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("response with nothing outstanding: status %0d count %0d",
                                      st, c));
            return;
         end
         e = expected_rsp.pop_front();
         n_checked++;
         if (st !== e.status)
            report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
         if (d !== e.data)
            report_mismatch($sformatf("head_data %h, expected %h", d, e.data));
         if (p !== e.prio)
            report_mismatch($sformatf("head_priority %h, expected %h", p, e.prio));
         if (c !== e.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d", c, e.count));
      endtask

      task drain_check();
         if (expected_rsp.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));
      endtask
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [spq_pkg::FUNC_W-1:0]        req_func = spq_pkg::FUNC_ENQ;
   logic signed [spq_pkg::DATA_W-1:0] req_item_data = '0;
   logic signed [spq_pkg::PRIO_W-1:0] req_item_priority = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [spq_pkg::STATUS_W-1:0]      rsp_status;
   logic signed [spq_pkg::DATA_W-1:0] rsp_head_data;
   logic signed [spq_pkg::PRIO_W-1:0] rsp_head_priority;
   logic [spq_pkg::CNT_W-1:0]         rsp_entry_count;

   queue_scoreboard sb = new();
   int burst_left = 1;

   sorted_priority_queue_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_head_data     (rsp_head_data),
      .rsp_head_priority (rsp_head_priority),
      .rsp_entry_count   (rsp_entry_count)
   );

   always #4 clock = ~clock;

   // receiver backpressure, switching between patterns now and then
   rx_mode_type rx_mode = RX_ALWAYS;
   int          rx_left = 0;
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(20, 120);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_ALWAYS:   rsp_ready <= 1'b1;
         RX_MOSTLY:   rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_RARELY:   rsp_ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_ready <= (rx_left % 9 == 0);
      endcase
   end

   // response checked before request noted; a response never belongs to this edge's request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_status, rsp_head_data, rsp_head_priority, rsp_entry_count);
         if (req_valid && req_ready)
            sb.note_request(req_func, req_item_data, req_item_priority);
      end
   end

   task send_request(logic [spq_pkg::FUNC_W-1:0] func, logic signed [spq_pkg::DATA_W-1:0] d,
                     logic signed [spq_pkg::PRIO_W-1:0] p);
      req_valid         <= 1'b1;
      req_func          <= func;
      req_item_data     <= d;
      req_item_priority <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task idle_gap(int cycles);
      req_valid         <= 1'b0;
      req_func          <= spq_pkg::FUNC_W'($urandom());
      req_item_data     <= spq_pkg::DATA_W'($urandom());
      req_item_priority <= spq_pkg::PRIO_W'($urandom());
      repeat (cycles) @(posedge clock);
   endtask

   // send, then close the burst with a gap when it runs out
   task send_paced(logic [spq_pkg::FUNC_W-1:0] func, logic signed [spq_pkg::DATA_W-1:0] d,
                   logic signed [spq_pkg::PRIO_W-1:0] p);
      send_request(func, d, p);
      burst_left--;
      if (burst_left <= 0) begin
         idle_gap($urandom_range(1, 10));
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 25);
      end
   endtask

   task hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   function logic signed [spq_pkg::PRIO_W-1:0] pick_priority(prio_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         PRIO_TIES:    return $signed(spq_pkg::PRIO_W'($urandom_range(0, 3))) - 16'sd1;
         PRIO_EXTREME: begin
            if (r < 40) return 16'sh7fff;
            if (r < 80) return 16'sh8000;
            return spq_pkg::PRIO_W'($urandom());
         end
         default:      return spq_pkg::PRIO_W'($urandom());
      endcase
   endfunction

   function logic signed [spq_pkg::DATA_W-1:0] pick_data();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 32'sh7fffffff;
      if (r == 1) return 32'sh80000000;
      if (r == 2) return '0;
      return spq_pkg::DATA_W'($urandom());
   endfunction

   function logic [spq_pkg::FUNC_W-1:0] pick_func(segment_type seg);
      int r;
      int enq_top;
      int deq_top;
      r = $urandom_range(0, 99);
      case (seg)
         SEG_FILL:  begin enq_top = 75; deq_top = 90; end
         SEG_DRAIN: begin enq_top = 25; deq_top = 80; end
         default:   begin enq_top = 50; deq_top = 82; end
      endcase
      if (r < 3)       return FUNC_UNUSED;
      if (r < enq_top) return spq_pkg::FUNC_ENQ;
      if (r < deq_top) return spq_pkg::FUNC_DEQ;
      return spq_pkg::FUNC_PEEK;
   endfunction

   initial begin
      int counted;
      int seg_len;
      segment_type seg;
      prio_mode_type pmode;
      logic [spq_pkg::FUNC_W-1:0] f;
      counted = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, extremes, ties, fill to full and one rejected insert
      send_request(spq_pkg::FUNC_DEQ, '0, '0);
      send_request(spq_pkg::FUNC_PEEK, '0, '0);
      send_request(FUNC_UNUSED, 32'sh7fffffff, 16'sh7fff);
      send_request(spq_pkg::FUNC_ENQ, 32'sh7fffffff, 16'sh8000);
      send_request(spq_pkg::FUNC_ENQ, 32'sh80000000, 16'sh7fff);
      send_request(spq_pkg::FUNC_ENQ, 32'sh00000000, 16'sh0000);
      send_request(spq_pkg::FUNC_ENQ, -32'sd1, -16'sd1);
      send_request(spq_pkg::FUNC_ENQ, 32'sd1, 16'sd5);
      send_request(spq_pkg::FUNC_ENQ, 32'sd2, 16'sd5);
      send_request(spq_pkg::FUNC_ENQ, 32'sd3, 16'sd5);
      send_request(spq_pkg::FUNC_ENQ, 32'sh5555aaaa, 16'sh7fff);
      send_request(spq_pkg::FUNC_ENQ, 32'shaaaa5555, 16'sh8000);
      send_request(spq_pkg::FUNC_ENQ, 32'sd4, 16'sd5);
      send_request(spq_pkg::FUNC_ENQ, 32'sh12345678, 16'sh0001);
      send_request(spq_pkg::FUNC_ENQ, 32'shfedcba98, -16'sd2);
      send_request(spq_pkg::FUNC_ENQ, 32'sh0f0f0f0f, 16'sh7ffe);
      send_request(spq_pkg::FUNC_ENQ, 32'shf0f0f0f0, 16'sh8001);
      send_request(spq_pkg::FUNC_ENQ, 32'sd5, 16'sd5);
      send_request(spq_pkg::FUNC_ENQ, 32'sh7ffffffe, 16'sh0000);
      send_request(spq_pkg::FUNC_ENQ, 32'sh01010101, 16'sh1234);
      send_request(spq_pkg::FUNC_PEEK, '0, '0);
      send_request(FUNC_UNUSED, -32'sd1, -16'sd1);
      send_request(spq_pkg::FUNC_DEQ, '0, '0);
      send_request(spq_pkg::FUNC_DEQ, '0, '0);
      send_request(spq_pkg::FUNC_DEQ, '0, '0);

      // pause with no requests sent until all responses are back
      hold_until_drained();

      while (counted < RANDOM_ITEMS) begin
         seg   = segment_type'($urandom_range(0, 2));
         pmode = prio_mode_type'($urandom_range(0, 2));
         seg_len = $urandom_range(20, 80);
         for (int i = 0; i < seg_len; i++) begin
            f = pick_func(seg);
            send_paced(f, pick_data(), pick_priority(pmode));
            if (f != FUNC_UNUSED) counted++;
         end
         if ($urandom_range(0, 5) == 0) hold_until_drained();
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.drain_check();
      $display("checked %0d responses: %0d inserts, %0d full rejects, %0d removals, %0d peeks",
               sb.n_checked, sb.n_enq, sb.n_full, sb.n_deq, sb.n_peek);
      $display("%0d empty replies, %0d unused-code requests, deepest fill %0d of %0d",
               sb.n_empty, sb.n_unused, sb.max_fill, spq_pkg::DEPTH);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d responses outstanding", sb.outstanding());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### sorted_priority_queue_top.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
tb/sv/sorted_priority_queue_top_tb.sv
